FILE: design/assert_macros.svh
// Assertion helpers shared by the design files.
// Each macro places a labelled concurrent assertion clocked on the rising edge
// and quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LSB steganography extractor.
// ----------------------------------------------------------------------------
package lse_pkg;

  // Longest extension before an overflow is flagged
  localparam int MAX_EXT_LEN = 10;
  localparam int EXT_CNT_W   = $clog2(MAX_EXT_LEN + 1);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_EXT  = 1'b1;

  // Extraction modes; code 3 behaves as one LSB per byte
  localparam logic [1:0] MODE_LSB1 = 2'd0;
  localparam logic [1:0] MODE_LSB4 = 2'd1;
  localparam logic [1:0] MODE_LSBI = 2'd2;

  localparam int SIZE_W = 32;

  typedef enum logic [1:0] {
    KIND_SIZE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_EXT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       ext_follows;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data_byte;
    logic [SIZE_W-1:0] size;
    logic              last;
    logic              ovf;
  } res_t;

endpackage

FILE: design/lse_parser.sv
// ----------------------------------------------------------------------------
// lse_parser
// Bit gathering and message parse: one carrier byte per transaction, at most
// one result per byte, computed in a single pass from the held parse state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lse_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    carrier,
  input  logic          first,
  input  lse_pkg::cfg_t cfg,
  output logic          res_valid,
  output lse_pkg::res_t res
);
  import lse_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_PATTERN,
    PH_SIZE,
    PH_DATA,
    PH_EXT,
    PH_DONE
  } phase_t;

  phase_t               phase, phase_next;
  logic [3:0]           invert_flags, invert_flags_next;
  logic [7:0]           bit_accumulator, bit_accumulator_next;
  logic [2:0]           bits_collected, bits_collected_next;
  logic [SIZE_W-1:0]    size_shift, size_shift_next;
  logic [SIZE_W-1:0]    bytes_remaining, bytes_remaining_next;
  logic [1:0]           header_count, header_count_next;
  logic [EXT_CNT_W-1:0] ext_count, ext_count_next;

  logic                 restart;
  phase_t               ph0;
  logic [3:0]           flags0;
  logic [7:0]           acc0;
  logic [2:0]           bits0;
  logic [SIZE_W-1:0]    size0;
  logic [SIZE_W-1:0]    rem0;
  logic [1:0]           hc0;
  logic [EXT_CNT_W-1:0] ec0;

  logic [7:0]           acc_shift;
  logic [3:0]           bit_sum;
  logic                 lsb;
  logic                 complete;
  logic [SIZE_W-1:0]    rem_dec;
  logic [EXT_CNT_W-1:0] ec_inc;

  // Restart clears the parse before this byte is handled
  always_comb begin
    restart = first || (phase == PH_START);
    ph0     = restart ? ((cfg.mode == MODE_LSBI) ? PH_PATTERN : PH_SIZE) : phase;
    flags0  = restart ? 4'd0 : invert_flags;
    acc0    = restart ? 8'd0 : bit_accumulator;
    bits0   = restart ? 3'd0 : bits_collected;
    size0   = restart ? '0 : size_shift;
    rem0    = restart ? '0 : bytes_remaining;
    hc0     = restart ? 2'd0 : header_count;
    ec0     = restart ? '0 : ext_count;
  end

  // Gather the carrier bits, MSB first
  always_comb begin
    lsb = carrier[0] ^ ((cfg.mode == MODE_LSBI) ? flags0[carrier[2:1]] : 1'b0);
    if (cfg.mode == MODE_LSB4) begin
      acc_shift = {acc0[3:0], carrier[3:0]};
      bit_sum   = {1'b0, bits0} + 4'd4;
    end else begin
      acc_shift = {acc0[6:0], lsb};
      bit_sum   = {1'b0, bits0} + 4'd1;
    end
    complete = bit_sum[3];
    rem_dec  = rem0 - SIZE_W'(1);
    ec_inc   = ec0 + EXT_CNT_W'(1);
  end

  // Parse step
  always_comb begin
    phase_next           = ph0;
    invert_flags_next    = flags0;
    bit_accumulator_next = acc0;
    bits_collected_next  = bits0;
    size_shift_next      = size0;
    bytes_remaining_next = rem0;
    header_count_next    = hc0;
    ext_count_next       = ec0;
    res_valid            = 1'b0;
    res.kind             = KIND_SIZE;
    res.data_byte        = acc_shift;
    res.size             = size0;
    res.last             = 1'b0;
    res.ovf              = 1'b0;

    if (ph0 == PH_PATTERN) begin
      invert_flags_next = flags0 | (4'(carrier[0]) << hc0);
      header_count_next = hc0 + 2'd1;
      if (hc0 == 2'd3) begin
        phase_next = PH_SIZE;
      end
    end else if (ph0 != PH_DONE) begin
      if (complete) begin
        bit_accumulator_next = 8'd0;
        bits_collected_next  = 3'd0;
      end else begin
        bit_accumulator_next = acc_shift;
        bits_collected_next  = bit_sum[2:0];
      end

      if (complete) begin
        unique case (ph0)
          PH_SIZE: begin
            size_shift_next   = {size0[SIZE_W-9:0], acc_shift};
            header_count_next = hc0 + 2'd1;
            res.size          = size_shift_next;
            res.data_byte     = 8'd0;
            res.kind          = KIND_SIZE;
            if (hc0 == 2'd3) begin
              res_valid            = 1'b1;
              bytes_remaining_next = size_shift_next;
              if (size_shift_next != '0) begin
                phase_next = PH_DATA;
              end else if (cfg.ext_follows) begin
                phase_next = PH_EXT;
              end else begin
                phase_next = PH_DONE;
                res.last   = 1'b1;
              end
            end
          end
          PH_DATA: begin
            res_valid            = 1'b1;
            res.kind             = KIND_DATA;
            bytes_remaining_next = rem_dec;
            if (rem_dec == '0) begin
              if (cfg.ext_follows) begin
                phase_next = PH_EXT;
              end else begin
                phase_next = PH_DONE;
                res.last   = 1'b1;
              end
            end
          end
          PH_EXT: begin
            res_valid      = 1'b1;
            res.kind       = KIND_EXT;
            ext_count_next = ec_inc;
            if (acc_shift == 8'd0) begin
              phase_next = PH_DONE;
              res.last   = 1'b1;
            end else if (ec_inc >= EXT_CNT_W'(MAX_EXT_LEN)) begin
              phase_next = PH_DONE;
              res.last   = 1'b1;
              res.ovf    = 1'b1;
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  // Hold parse state; advance on each accepted carrier byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      invert_flags    <= 4'd0;
      bit_accumulator <= 8'd0;
      bits_collected  <= 3'd0;
      size_shift      <= '0;
      bytes_remaining <= '0;
      header_count    <= 2'd0;
      ext_count       <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      invert_flags    <= invert_flags_next;
      bit_accumulator <= bit_accumulator_next;
      bits_collected  <= bits_collected_next;
      size_shift      <= size_shift_next;
      bytes_remaining <= bytes_remaining_next;
      header_count    <= header_count_next;
      ext_count       <= ext_count_next;
    end
  end

  `ASSERT_SAME(a_done_silent, clk, rst, fire && !first && phase == PH_DONE, !res_valid, "result after message end")
  `ASSERT_NEXT(a_last_ends, clk, rst, fire && res_valid && res.last, phase == PH_DONE, "last result did not end the message")
  `ASSERT_SAME(a_ovf_last, clk, rst, res_valid && res.ovf, res.last && res.kind == KIND_EXT, "overflow on a non-final result")
  `ASSERT_NEXT(a_ext_bound, clk, rst, fire, ext_count <= EXT_CNT_W'(MAX_EXT_LEN), "extension count past its cap")

endmodule

FILE: design/lsb_stego_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// Recovers a hidden size, payload and extension from the low bits of a
// stream of image pixel bytes (LSB1, LSB4 or pattern-inverted LSB).
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         carrier byte in tdata, first-of-image in tuser
//  m_*       out        byte and size in tdata, kind and overflow in tuser, last
//  APB       in/out     stego_mode at 0x0, extension_follows at 0x4
//
// One carrier byte is accepted every cycle unless stalled; its result, if any,
// is registered, in the skid entry while m_* stalls. Parse state lives in the
// parser and updates on each accepted byte. A two-entry output stage (result
// register plus skid) lets the slave side keep running while one result waits;
// the slave side stalls only when both entries are full. Synchronous reset
// returns the registers to LSB1 with extension enabled and the parse to start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsb_stego_extractor (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lse_pkg::PADDR_W-1:0] paddr,
  input  logic [lse_pkg::PDATA_W-1:0] pwdata,
  output logic [lse_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // Carrier stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] carrier_byte
  input  logic                        s_tuser,   // [0] first_of_image
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,   // [7:0] out_byte, [39:8] payload_size
  output logic [2:0]                  m_tuser,   // [1:0] out_kind, [2] ext_overflow
  output logic                        m_tlast    // last
);
  import lse_pkg::*;

  cfg_t cfg;
  logic fire;
  logic pop;
  logic res_valid;
  res_t res;
  res_t out_res;
  res_t skid_res;
  logic skid_valid;
  logic cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= MODE_LSB1;
      cfg.ext_follows <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODE: cfg.mode        <= pwdata[1:0];
        REG_EXT:  cfg.ext_follows <= pwdata[0];
        default:  cfg.ext_follows <= cfg.ext_follows;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE: prdata = {{(PDATA_W-2){1'b0}}, cfg.mode};
      REG_EXT:  prdata = {{(PDATA_W-1){1'b0}}, cfg.ext_follows};
      default:  prdata = '0;
    endcase
  end

  // Accept while the skid entry is free
  assign s_tready = !skid_valid;
  assign fire     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  lse_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .carrier   (s_tdata),
    .first     (s_tuser),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (fire && res_valid) begin
        if (!m_tvalid || pop) begin
          m_tvalid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      if (!m_tvalid || pop) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end else if (pop && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign m_tdata = {out_res.size, out_res.data_byte};
  assign m_tuser = {out_res.ovf, out_res.kind};
  assign m_tlast = out_res.last;

  `ASSERT_SAME(a_skid_behind_main, clk, rst, skid_valid, m_tvalid, "skid entry full with empty output")
  `ASSERT_NEXT(a_stall_to_skid, clk, rst, fire && res_valid && m_tvalid && !m_tready, skid_valid, "stalled result not kept")
  `ASSERT_NEXT(a_skid_drains, clk, rst, pop && skid_valid, m_tvalid && $past(skid_res) == out_res, "skid entry not moved forward")

endmodule
